@@ hdl/tst_pkg.sv @@
// Shared types and codes for the timer slot table.
// No dependencies; tst_mem, tst_ctrl and timer_slot_table_core import this package.
`timescale 1ns / 1ps

package tst_pkg;

	// Command codes carried by a request
	localparam logic [2:0] CMD_ADD        = 3'd0;
	localparam logic [2:0] CMD_CHECK      = 3'd1;
	localparam logic [2:0] CMD_RESTART    = 3'd2;
	localparam logic [2:0] CMD_REMOVE     = 3'd3;
	localparam logic [2:0] CMD_REMOVE_ALL = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_ADDED    = 2'd0;
	localparam logic [1:0] KIND_REJECTED = 2'd1;
	localparam logic [1:0] KIND_FIRED    = 2'd2;

	// Upper bound on firings reported by one check
	localparam int MaxResults = 16;
	localparam int FireCntW   = $clog2(MaxResults + 1);

	// One result item
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] slot_id;
		logic       last;
	} tst_res_t;

	// Result handed from the sequencer to the output stage
	typedef struct packed {
		logic     vld;
		tst_res_t res;
	} tst_push_t;

	// One entry of the slot memory
	typedef struct packed {
		logic        periodic;
		logic [31:0] interval;
		logic [31:0] tick;
	} tst_entry_t;

endpackage

@@ hdl/tst_if.sv @@
// Request and result channel interfaces of the timer slot table.
// Depends on nothing; used by tst_ctrl and timer_slot_table_core.
`timescale 1ns / 1ps

interface tst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] now_tick;
	logic [31:0] interval;
	logic        repeat_req;
	logic        has_handler;
	logic [3:0]  slot;

	modport source (output valid, cmd, now_tick, interval, repeat_req, has_handler, slot,
		input ready);
	modport sink (input valid, cmd, now_tick, interval, repeat_req, has_handler, slot,
		output ready);
endinterface

interface tst_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] slot_id;
	logic       last;

	modport source (output valid, kind, slot_id, last, input ready);
	modport sink (input valid, kind, slot_id, last, output ready);
endinterface

@@ hdl/tst_mem.sv @@
// Slot memory: periodic flag, interval and last tick of every slot.
// One read port with registered data, one write port with separate enables
// for the configuration part and the tick part. Depends on tst_pkg.
`timescale 1ns / 1ps

module tst_mem import tst_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                                       clk,
	input  logic                                       rd_en,
	input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
	output tst_entry_t                                 rd_data,
	input  logic                                       wr_cfg_en,
	input  logic                                       wr_tick_en,
	input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
	input  tst_entry_t                                 wr_data
);

	logic        periodic_mem [NUM_SLOTS];
	logic [31:0] interval_mem [NUM_SLOTS];
	logic [31:0] tick_mem     [NUM_SLOTS];

	// Write the configuration part and the tick part independently
	always_ff @(posedge clk) begin
		if (wr_cfg_en) begin
			periodic_mem[wr_addr] <= wr_data.periodic;
			interval_mem[wr_addr] <= wr_data.interval;
		end
		if (wr_tick_en) begin
			tick_mem[wr_addr] <= wr_data.tick;
		end
	end

	// Register read data; hold it while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data.periodic <= periodic_mem[rd_addr];
			rd_data.interval <= interval_mem[rd_addr];
			rd_data.tick     <= tick_mem[rd_addr];
		end
	end

endmodule

@@ hdl/tst_ctrl.sv @@
// Command sequencer of the timer slot table: valid bits, add/restart/remove
// handling and the check scan over the slot memory. Depends on tst_pkg, tst_if.
`timescale 1ns / 1ps

module tst_ctrl import tst_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	tst_req_if.sink                                    req,
	input  logic                                       out_free,
	output tst_push_t                                  push,
	output logic                                       rd_en,
	output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
	input  tst_entry_t                                 rd_data,
	output logic                                       wr_cfg_en,
	output logic                                       wr_tick_en,
	output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
	output tst_entry_t                                 wr_data
);

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int EW = (AW > 4) ? AW : 4;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]           state_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [31:0]          now_q;
	logic [CW-1:0]        rd_idx_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic [FireCntW-1:0]  fire_cnt_q;
	logic                 pend_vld_q;
	logic [AW-1:0]        pend_idx_q;

	logic          accept;
	logic          free_found;
	logic [AW-1:0] free_idx;
	logic [EW-1:0] idx_ext;
	logic [AW-1:0] sel_idx;
	logic          idx_in_range;
	logic          add_ok;
	logic [31:0]   elapsed;
	logic          due;
	logic          stall;
	logic          eval_go;
	logic          fire;
	logic          stop;
	logic          rd_more;
	logic          issue;
	logic          scan_done;

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	// Decode the addressed slot of restart and remove
	assign idx_ext      = EW'(req.slot);
	assign sel_idx      = idx_ext[AW-1:0];
	assign idx_in_range = {28'd0, req.slot} < 32'(NUM_SLOTS);

	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign add_ok    = (req.interval != 32'd0) && req.has_handler && free_found;

	// Evaluate the slot whose entry came back from memory
	assign elapsed   = now_q - rd_data.tick;
	assign due       = valid_q[rd_idx_s1] && (elapsed >= rd_data.interval);
	assign stall     = due && pend_vld_q && !out_free;
	assign eval_go   = rd_vld_s1 && !stall;
	assign fire      = eval_go && due;
	assign stop      = fire && (fire_cnt_q == FireCntW'(MaxResults - 1));
	assign rd_more   = rd_idx_q < CW'(NUM_SLOTS);
	assign issue     = (state_q == ST_SCAN) && rd_more && !stop && (!rd_vld_s1 || !stall);
	assign scan_done = (state_q == ST_SCAN) && (stop || (!rd_more && !rd_vld_s1));

	assign rd_en   = issue;
	assign rd_addr = rd_idx_q[AW-1:0];

	// Drive the memory write port
	always_comb begin
		wr_cfg_en  = 1'b0;
		wr_tick_en = 1'b0;
		wr_addr    = rd_idx_s1;
		wr_data    = '{periodic: req.repeat_req, interval: req.interval, tick: now_q};
		if (state_q == ST_SCAN) begin
			wr_tick_en = fire;
		end else if (accept) begin
			wr_data.tick = req.now_tick;
			case (req.cmd)
				CMD_ADD: begin
					wr_cfg_en  = add_ok;
					wr_tick_en = add_ok;
					wr_addr    = free_idx;
				end
				CMD_RESTART: begin
					wr_tick_en = idx_in_range && valid_q[sel_idx];
					wr_addr    = sel_idx;
				end
				default: begin
					wr_cfg_en  = 1'b0;
				end
			endcase
		end
	end

	// Hand results to the output stage
	always_comb begin
		push = '0;
		if (state_q == ST_SCAN) begin
			push.vld = fire && pend_vld_q;
			push.res = '{kind: KIND_FIRED, slot_id: 4'(pend_idx_q), last: 1'b0};
		end else if (state_q == ST_FLUSH) begin
			push.vld = pend_vld_q && out_free;
			push.res = '{kind: KIND_FIRED, slot_id: 4'(pend_idx_q), last: 1'b1};
		end else if (accept && (req.cmd == CMD_ADD)) begin
			push.vld = 1'b1;
			if (add_ok) begin
				push.res = '{kind: KIND_ADDED, slot_id: 4'(free_idx), last: 1'b1};
			end else begin
				push.res = '{kind: KIND_REJECTED, slot_id: 4'd0, last: 1'b1};
			end
		end
	end

	// Sequence commands and the check scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			fire_cnt_q <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_ADD: begin
								if (add_ok) begin
									valid_q[free_idx] <= 1'b1;
								end
							end
							CMD_CHECK: begin
								state_q    <= ST_SCAN;
								rd_idx_q   <= '0;
								rd_vld_s1  <= 1'b0;
								fire_cnt_q <= '0;
								pend_vld_q <= 1'b0;
							end
							CMD_REMOVE: begin
								if (idx_in_range) begin
									valid_q[sel_idx] <= 1'b0;
								end
							end
							CMD_REMOVE_ALL: begin
								valid_q <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q  <= rd_idx_q + CW'(1);
						rd_vld_s1 <= 1'b1;
					end else if (eval_go || stop) begin
						rd_vld_s1 <= 1'b0;
					end
					if (fire) begin
						pend_vld_q <= 1'b1;
						fire_cnt_q <= fire_cnt_q + FireCntW'(1);
						if (!rd_data.periodic) begin
							valid_q[rd_idx_s1] <= 1'b0;
						end
					end
					if (scan_done) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_vld_q || out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture payload of the scan pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= req.now_tick;
		end
		if (issue) begin
			rd_idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (fire) begin
			pend_idx_q <= rd_idx_s1;
		end
	end

endmodule

@@ hdl/timer_slot_table_core.sv @@
// Timer slot table: add, restart and remove take one request per cycle
// while the result output is free; add gives its result in the cycle after
// acceptance. Check reads one slot per cycle from the single slot memory read
// port while the output does not stall; the next request waits until it ends.
// Reset clears every valid bit at once; memory contents stay unknown until an
// add writes them. Depends on tst_pkg, tst_if, tst_mem and tst_ctrl.
`timescale 1ns / 1ps

module timer_slot_table_core import tst_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tst_req_if.sink   req,
	tst_res_if.source res
);

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	tst_push_t  push;
	logic       out_free;
	logic       out_vld_q;
	tst_res_t   out_q;
	logic       rd_en;
	logic [AW-1:0] rd_addr;
	tst_entry_t rd_data;
	logic       wr_cfg_en;
	logic       wr_tick_en;
	logic [AW-1:0] wr_addr;
	tst_entry_t wr_data;

	tst_ctrl #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.out_free   (out_free),
		.push       (push),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_cfg_en  (wr_cfg_en),
		.wr_tick_en (wr_tick_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	tst_mem #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_mem (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_cfg_en  (wr_cfg_en),
		.wr_tick_en (wr_tick_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// Output register: free when empty or drained this cycle
	assign out_free = !out_vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push.vld) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld) begin
			out_q <= push.res;
		end
	end

	assign res.valid   = out_vld_q;
	assign res.kind    = out_q.kind;
	assign res.slot_id = out_q.slot_id;
	assign res.last    = out_q.last;

endmodule
